// ----- sv/gdad_pkg.sv -----
// package for the gregorian date add days block
// holds field widths, calendar constants, the month length table and the sequencer states

package gdad_pkg;

    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 17;
    localparam int R400_W  = 9;
    localparam int QUOT_W  = 6;

    localparam logic [YEAR_W-1:0]  MIN_YEAR   = 14'd1800;
    localparam logic [YEAR_W-1:0]  MAX_YEAR   = 14'd10000;
    localparam logic [YEAR_W-1:0]  YEAR_CYCLE = 14'd400;
    localparam logic [R400_W-1:0]  CYCLE_LAST = 9'd399;
    localparam logic [R400_W-1:0]  CENTURY_1  = 9'd100;
    localparam logic [R400_W-1:0]  CENTURY_2  = 9'd200;
    localparam logic [R400_W-1:0]  CENTURY_3  = 9'd300;

    // y / 400 as (y * RECIP) >> RECIP_SHIFT, exact for all 14-bit years
    localparam logic [YEAR_W-1:0]  RECIP       = 14'd10486;
    localparam int                 RECIP_SHIFT = 22;

    localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
    localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;
    localparam logic [DAY_W-1:0]   FIRST_DAY = 5'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_REM,
        ST_CHECK,
        ST_STEP,
        ST_DONE
    } state_t;

    // leap rule from the low year bits and the year modulo 400
    function automatic logic is_leap(input logic [1:0] year_lo, input logic [R400_W-1:0] r400);
        is_leap = (year_lo == 2'd0) && (r400 != CENTURY_1) && (r400 != CENTURY_2)
                  && (r400 != CENTURY_3);
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        case (m)
            4'd1:    month_days = 5'd31;
            4'd2:    month_days = leap ? 5'd29 : 5'd28;
            4'd3:    month_days = 5'd31;
            4'd4:    month_days = 5'd30;
            4'd5:    month_days = 5'd31;
            4'd6:    month_days = 5'd30;
            4'd7:    month_days = 5'd31;
            4'd8:    month_days = 5'd31;
            4'd9:    month_days = 5'd30;
            4'd10:   month_days = 5'd31;
            4'd11:   month_days = 5'd30;
            4'd12:   month_days = 5'd31;
            default: month_days = 5'd0;
        endcase
    endfunction

endpackage

// ----- sv/gdad_if.sv -----
// valid/ready channel interfaces for the date add block
// depends on gdad_pkg for the field widths

interface gdad_req_if;
    import gdad_pkg::*;
    logic               valid;
    logic               ready;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [YEAR_W-1:0]  start_year;
    logic [COUNT_W-1:0] days_to_add;

    modport source (output valid, start_month, start_day, start_year, days_to_add,
                    input ready);
    modport sink (input valid, start_month, start_day, start_year, days_to_add,
                  output ready);
endinterface

interface gdad_rsp_if;
    import gdad_pkg::*;
    logic               valid;
    logic               ready;
    logic [MONTH_W-1:0] end_month;
    logic [DAY_W-1:0]   end_day;
    logic [YEAR_W-1:0]  end_year;
    logic               input_error;

    modport source (output valid, end_month, end_day, end_year, input_error,
                    input ready);
    modport sink (input valid, end_month, end_day, end_year, input_error,
                  output ready);
endinterface

// ----- sv/gregorian_date_add_days_top.sv -----
// gregorian date plus days, stepped one month per cycle
// depends on gdad_pkg and the channel interfaces in gdad_if
//
// usage:
//   req channel carries start_month, start_day, start_year and days_to_add;
//   rsp channel returns end_month, end_day, end_year and input_error.
//   an item is taken when valid and ready are both high at a clock edge.
// sequence:
//   the item is taken in the idle state, followed by the year/400 multiply, the
//   remainder and validation states, then the step state crosses one month at a
//   time and ends with the final day add, and the done state loads the result
//   register. an invalid date goes from validation straight to the done state.
// throughput:
//   one item at a time; req.ready is high only while the sequencer is idle.
//   a finished result waits in its own register, so the next item can be
//   taken while the receiver has not yet accepted the previous one.
// reset:
//   rst_n clears the sequencer and the result valid.
// stall:
//   if rsp.ready is low the result holds, and a later finished item waits
//   in the done state until the result register is free.

module gregorian_date_add_days_top (
    input  logic        clk,
    input  logic        rst_n,
    gdad_req_if.sink    req,
    gdad_rsp_if.source  rsp
);
    import gdad_pkg::*;

    state_t               state_reg, state_next;
    logic [MONTH_W-1:0]   m_reg, m_next;
    logic [DAY_W-1:0]     d_reg, d_next;
    logic [YEAR_W-1:0]    y_reg, y_next;
    logic [COUNT_W-1:0]   left_reg, left_next;
    logic [QUOT_W-1:0]    q_reg, q_next;
    logic [R400_W-1:0]    r400_reg, r400_next;
    logic                 bad_reg, bad_next;

    logic                 out_valid_reg, out_valid_next;
    logic [MONTH_W-1:0]   end_month_reg, end_month_next;
    logic [DAY_W-1:0]     end_day_reg, end_day_next;
    logic [YEAR_W-1:0]    end_year_reg, end_year_next;
    logic                 err_reg, err_next;

    logic [2*YEAR_W-1:0]  recip_prod;
    logic [YEAR_W-1:0]    q_times_cycle;
    logic [YEAR_W-1:0]    rem_raw;
    logic                 leap;
    logic [DAY_W-1:0]     mlen;
    logic [DAY_W-1:0]     rest;
    logic                 out_free;
    logic                 start_bad;

    assign recip_prod    = (2*YEAR_W)'(y_reg) * (2*YEAR_W)'(RECIP);
    assign q_times_cycle = YEAR_W'(q_reg) * YEAR_CYCLE;
    assign rem_raw       = y_reg - q_times_cycle;
    assign leap          = is_leap(y_reg[1:0], r400_reg);
    assign mlen          = month_days(m_reg, leap);
    assign rest          = mlen - d_reg;
    assign out_free      = !out_valid_reg || rsp.ready;
    assign start_bad     = (y_reg < MIN_YEAR) || (y_reg > MAX_YEAR) || (m_reg < JANUARY)
                           || (m_reg > DECEMBER) || (d_reg == '0) || (d_reg > mlen);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:   state_next = ST_REM;
            ST_REM:   state_next = ST_CHECK;
            ST_CHECK: state_next = start_bad ? ST_DONE : ST_STEP;
            ST_STEP:
            begin
                if ((left_reg == '0) || (left_reg <= COUNT_W'(rest)))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        m_next         = m_reg;
        d_next         = d_reg;
        y_next         = y_reg;
        left_next      = left_reg;
        q_next         = q_reg;
        r400_next      = r400_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        end_month_next = end_month_reg;
        end_day_next   = end_day_reg;
        end_year_next  = end_year_reg;
        err_next       = err_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    m_next    = req.start_month;
                    d_next    = req.start_day;
                    y_next    = req.start_year;
                    left_next = req.days_to_add;
                end
            end
            ST_DIV:
            begin
                q_next = recip_prod[RECIP_SHIFT +: QUOT_W];
            end
            ST_REM:
            begin
                if (rem_raw >= YEAR_CYCLE)
                begin
                    r400_next = R400_W'(rem_raw - YEAR_CYCLE);
                end
                else
                begin
                    r400_next = R400_W'(rem_raw);
                end
            end
            ST_CHECK:
            begin
                bad_next = start_bad;
            end
            ST_STEP:
            begin
                if (left_reg > COUNT_W'(rest))
                begin
                    // jump to the first day of the next month
                    left_next = left_reg - COUNT_W'(rest) - COUNT_W'(1);
                    d_next    = FIRST_DAY;
                    if (m_reg == DECEMBER)
                    begin
                        m_next    = JANUARY;
                        y_next    = y_reg + YEAR_W'(1);
                        r400_next = (r400_reg == CYCLE_LAST) ? '0 : r400_reg + R400_W'(1);
                    end
                    else
                    begin
                        m_next = m_reg + MONTH_W'(1);
                    end
                end
                else
                begin
                    d_next    = d_reg + left_reg[DAY_W-1:0];
                    left_next = '0;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    end_month_next = m_reg;
                    end_day_next   = d_reg;
                    end_year_next  = y_reg;
                    err_next       = bad_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !rsp.ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg         <= m_next;
        d_reg         <= d_next;
        y_reg         <= y_next;
        left_reg      <= left_next;
        q_reg         <= q_next;
        r400_reg      <= r400_next;
        bad_reg       <= bad_next;
        end_month_reg <= end_month_next;
        end_day_reg   <= end_day_next;
        end_year_reg  <= end_year_next;
        err_reg       <= err_next;
    end

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.end_month   = end_month_reg;
    assign rsp.end_day     = end_day_reg;
    assign rsp.end_year    = end_year_reg;
    assign rsp.input_error = err_reg;

    // month walk only runs on a validated date
    a_step_valid_month: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> (m_reg >= JANUARY) && (m_reg <= DECEMBER) && !bad_reg)
        else $error("month walk on invalid date");

    a_step_day_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> (d_reg != '0) && (d_reg <= mlen))
        else $error("day beyond month length during walk");

    a_r400_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK || state_reg == ST_STEP) |-> (r400_reg <= CYCLE_LAST))
        else $error("year remainder out of range");

    // remainder counter stays in step with the year as it advances
    a_r400_tracks_year: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) && $past(state_reg == ST_STEP) && (y_reg != $past(y_reg))
        |-> (r400_reg == (($past(r400_reg) == CYCLE_LAST) ? '0 : $past(r400_reg) + R400_W'(1))))
        else $error("year remainder lost track of the year");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && out_free |=> rsp.valid && (rsp.input_error == $past(bad_reg)))
        else $error("finished item not loaded into the result register");

endmodule
